FILE: sv/cdeq_pkg.sv
// Shared types, widths and operation codes for the circular deque.
package cdeq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int WORD_W    = 32;
    localparam int MODE_W    = 3;
    localparam int OCC_W     = 5;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic        [MODE_W-1:0] t_mode;

    localparam t_mode MODE_PUSH_FRONT = 3'd0;
    localparam t_mode MODE_PUSH_REAR  = 3'd1;
    localparam t_mode MODE_POP_FRONT  = 3'd2;
    localparam t_mode MODE_POP_REAR   = 3'd3;
    localparam t_mode MODE_STATUS     = 3'd4;

    localparam t_word WORD_NONE = '1;   // -1, reported for absent words

    // One operation broadcast to every cell; at most one bit set.
    typedef struct packed {
        logic push_front;
        logic push_rear;
        logic pop_front;
        logic pop_rear;
    } t_cell_cmd;

endpackage

FILE: sv/cdeq_cell.sv
// One storage cell of the deque chain: a word, its valid bit, neighbor moves.
module cdeq_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cdeq_pkg::t_cell_cmd i_cmd,
    input  cdeq_pkg::t_word     i_push_value,
    input  cdeq_pkg::t_word     i_prev_data,
    input  logic                i_prev_vld,
    input  cdeq_pkg::t_word     i_next_data,
    input  logic                i_next_vld,
    output cdeq_pkg::t_word     o_data,
    output logic                o_vld,
    output cdeq_pkg::t_word     o_rear_tap
);

    cdeq_pkg::t_word r_data, n_data;
    logic            r_vld,  n_vld;
    logic            w_is_rear;
    logic            w_is_slot;

    assign w_is_rear = r_vld && !i_next_vld;   // last held word
    assign w_is_slot = !r_vld && i_prev_vld;   // first free slot

    always_comb begin
        n_data = r_data;
        n_vld  = r_vld;
        if (i_cmd.push_front) begin
            n_data = i_prev_data;
            n_vld  = i_prev_vld;
        end else if (i_cmd.pop_front) begin
            n_data = i_next_data;
            n_vld  = i_next_vld;
        end else if (i_cmd.push_rear && w_is_slot) begin
            n_data = i_push_value;
            n_vld  = 1'b1;
        end else if (i_cmd.pop_rear && w_is_rear) begin
            n_vld  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data     = r_data;
    assign o_vld      = r_vld;
    assign o_rear_tap = w_is_rear ? r_data : '0;

endmodule

FILE: sv/circular_double_ended_queue.sv
// Top level of the double-ended queue built as a shifting chain of cells.
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+-------------------------------------------
//  in      | i_valid | o_ready | i_mode, i_push_value
//  out     | o_valid | i_ready | o_accepted, o_popped_value, o_front_value,
//          |         |         | o_rear_value, o_is_empty, o_is_full,
//          |         |         | o_occupancy
//
// One beat per cycle sustained while the output side keeps taking results. A
// beat accepted at an edge updates the cell chain at that same edge, and its
// outcome waits in the hold stage; it is loaded into the output register,
// raising o_valid, once the output register is free to take it.
// The one-beat hold stage sits between chain and output register.
// Reset clears all valid bits and the count; the deque starts empty.
// When the output register is held and the hold stage is full, o_ready drops.
module circular_double_ended_queue #(
    parameter int DEPTH = cdeq_pkg::DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [cdeq_pkg::MODE_W-1:0]  i_mode,
    input  logic signed [cdeq_pkg::WORD_W-1:0] i_push_value,
    // output channel
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_accepted,
    output logic signed [cdeq_pkg::WORD_W-1:0] o_popped_value,
    output logic signed [cdeq_pkg::WORD_W-1:0] o_front_value,
    output logic signed [cdeq_pkg::WORD_W-1:0] o_rear_value,
    output logic                         o_is_empty,
    output logic                         o_is_full,
    output logic [cdeq_pkg::OCC_W-1:0]   o_occupancy
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // ---- cell chain -------------------------------------------------------
    // Cell 0 holds the front word; held words occupy cells 0..count-1.
    cdeq_pkg::t_word     w_data [DEPTH];
    logic                w_vld  [DEPTH];
    cdeq_pkg::t_word     w_tap  [DEPTH];
    cdeq_pkg::t_cell_cmd w_cmd;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            cdeq_pkg::t_word w_prev_data, w_next_data;
            logic            w_prev_vld,  w_next_vld;

            if (gi == 0) begin : g_head
                // head feeds from the incoming word; always "occupied" to its left
                assign w_prev_data = i_push_value;
                assign w_prev_vld  = 1'b1;
            end else begin : g_mid
                assign w_prev_data = w_data[gi-1];
                assign w_prev_vld  = w_vld[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_tail
                assign w_next_data = '0;
                assign w_next_vld  = 1'b0;
            end else begin : g_body
                assign w_next_data = w_data[gi+1];
                assign w_next_vld  = w_vld[gi+1];
            end

            cdeq_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_cmd       (w_cmd),
                .i_push_value(i_push_value),
                .i_prev_data (w_prev_data),
                .i_prev_vld  (w_prev_vld),
                .i_next_data (w_next_data),
                .i_next_vld  (w_next_vld),
                .o_data      (w_data[gi]),
                .o_vld       (w_vld[gi]),
                .o_rear_tap  (w_tap[gi])
            );
        end
    endgenerate

    // rear word: only the last valid cell drives its word onto its tap; others drive zero
    cdeq_pkg::t_word w_rear_or;
    always_comb begin
        w_rear_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_rear_or = w_rear_or | w_tap[i];
        end
    end

    // ---- occupancy --------------------------------------------------------
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_empty, w_full;

    assign w_empty = (r_count == '0);
    assign w_full  = (r_count == CNT_W'(DEPTH));

    // ---- handshake --------------------------------------------------------
    logic r_pend, n_pend;
    logic r_out_valid;
    logic w_out_free, w_load, w_in_fire;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_load     = r_pend && w_out_free;
    assign o_ready    = !r_pend || w_out_free;
    assign w_in_fire  = i_valid && o_ready;

    // ---- operation decode -------------------------------------------------
    logic            w_ok;
    cdeq_pkg::t_word w_popped;
    cdeq_pkg::t_cell_cmd w_op;

    always_comb begin
        w_op     = '0;
        w_ok     = 1'b1;
        w_popped = cdeq_pkg::WORD_NONE;
        n_count  = r_count;
        unique case (i_mode)
            cdeq_pkg::MODE_PUSH_FRONT, cdeq_pkg::MODE_PUSH_REAR: begin
                w_ok = !w_full;
                if (!w_full) begin
                    w_op.push_front = (i_mode == cdeq_pkg::MODE_PUSH_FRONT);
                    w_op.push_rear  = (i_mode == cdeq_pkg::MODE_PUSH_REAR);
                    n_count         = r_count + 1'b1;
                end
            end
            cdeq_pkg::MODE_POP_FRONT, cdeq_pkg::MODE_POP_REAR: begin
                w_ok = !w_empty;
                if (!w_empty) begin
                    w_op.pop_front = (i_mode == cdeq_pkg::MODE_POP_FRONT);
                    w_op.pop_rear  = (i_mode == cdeq_pkg::MODE_POP_REAR);
                    w_popped       = (i_mode == cdeq_pkg::MODE_POP_FRONT) ?
                                     w_data[0] : w_rear_or;
                    n_count        = r_count - 1'b1;
                end
            end
            default: begin
                // status and unused codes: report only
                w_ok = 1'b1;
            end
        endcase
    end

    assign w_cmd = w_in_fire ? w_op : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_in_fire) begin
            r_count <= n_count;
        end
    end

    // ---- hold stage: outcome of the beat now reflected in the chain --------
    logic            r_pend_ok;
    cdeq_pkg::t_word r_pend_popped;

    always_comb begin
        n_pend = r_pend;
        if (w_in_fire) begin
            n_pend = 1'b1;
        end else if (w_load) begin
            n_pend = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_pend_ok     <= w_ok;
            r_pend_popped <= w_popped;
        end
    end

    // ---- output register ---------------------------------------------------
    logic [CNT_W+cdeq_pkg::OCC_W-1:0] w_occ_ext;
    assign w_occ_ext = (CNT_W + cdeq_pkg::OCC_W)'(r_count);

    logic                        r_accepted, r_is_empty, r_is_full;
    cdeq_pkg::t_word             r_popped, r_front, r_rear;
    logic [cdeq_pkg::OCC_W-1:0]  r_occ;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // chain and count still show the held beat's state at this edge
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_accepted <= r_pend_ok;
            r_popped   <= r_pend_popped;
            r_front    <= w_empty ? cdeq_pkg::WORD_NONE : w_data[0];
            r_rear     <= w_empty ? cdeq_pkg::WORD_NONE : w_rear_or;
            r_is_empty <= w_empty;
            r_is_full  <= w_full;
            r_occ      <= w_occ_ext[cdeq_pkg::OCC_W-1:0];
        end
    end

    assign o_valid        = r_out_valid;
    assign o_accepted     = r_accepted;
    assign o_popped_value = r_popped;
    assign o_front_value  = r_front;
    assign o_rear_value   = r_rear;
    assign o_is_empty     = r_is_empty;
    assign o_is_full      = r_is_full;
    assign o_occupancy    = r_occ;

    // ---- assertions --------------------------------------------------------
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("count above depth");

    a_head_vld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vld[0] == (r_count != '0))
        else $error("head cell valid disagrees with count");

    a_tail_vld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vld[DEPTH-1] == w_full)
        else $error("tail cell valid disagrees with full");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.push_front, w_cmd.push_rear, w_cmd.pop_front, w_cmd.pop_rear}))
        else $error("more than one chain command");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && !w_out_free) |=> $stable(r_count))
        else $error("chain moved while result stalled");

endmodule
